// ----- src/rrat_pkg.sv -----
`timescale 1ns / 1ps
// rrat_pkg: shared types, codes and constants of the ack tracker
// no dependencies; used by the interfaces and every module under src but rrat_ram

package rrat_pkg;

    // fixed field widths of a packet header and of a reply
    localparam int SEQ_W  = 16;
    localparam int ACK_W  = 12;
    localparam int KIND_W = 2;

    // default size of the received map
    localparam int MAX_PACKETS_DEF = 1024;

    // handshake numbers
    localparam logic [SEQ_W-1:0] SYNACK_SEQ  = 16'd666;
    localparam logic [SEQ_W-1:0] CONFIRM_ACK = 16'd667;

    // reply kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SYNACK = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // transfer phase
    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_DATA    = 2'd2,
        PH_CLOSED  = 2'd3
    } t_phase;

    // controller sequencing states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REPLY
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic  load_item;
        logic  load_total;
        logic  clr_wr;
        logic  mark_wr;
        logic  cum_inc;
        logic  rd_issue;
        logic  out_load;
        t_kind kind;
        logic  closed;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic syn_ok;
        logic confirm_ok;
        logic data_ok;
        logic seq_is_cum;
        logic is_last;
        logic cum_below;
        logic rd_bit;
        logic out_free;
    } t_sts;

endpackage

// ----- src/rrat_in_if.sv -----
`timescale 1ns / 1ps
// rrat_in_if: packet header channel, valid/ready with header payload
// depends on rrat_pkg for field widths

interface rrat_in_if;
    logic                        valid;
    logic                        ready;
    logic                        syn_flag;
    logic                        ack_flag;
    logic [rrat_pkg::SEQ_W-1:0]  seq_number;
    logic [rrat_pkg::SEQ_W-1:0]  ack_number;

    modport source (output valid, syn_flag, ack_flag, seq_number, ack_number,
                    input ready);
    modport sink   (input valid, syn_flag, ack_flag, seq_number, ack_number,
                    output ready);
endinterface

// ----- src/rrat_out_if.sv -----
`timescale 1ns / 1ps
// rrat_out_if: reply channel, valid/ready with reply payload
// depends on rrat_pkg for field widths

interface rrat_out_if;
    logic                               valid;
    logic                               ready;
    logic        [rrat_pkg::KIND_W-1:0] reply_kind;
    logic        [rrat_pkg::SEQ_W-1:0]  reply_seq;
    logic signed [rrat_pkg::ACK_W-1:0]  reply_ack;
    logic                               closed_flag;

    modport source (output valid, reply_kind, reply_seq, reply_ack, closed_flag,
                    input ready);
    modport sink   (input valid, reply_kind, reply_seq, reply_ack, closed_flag,
                    output ready);
endinterface

// ----- src/rrat_ram.sv -----
`timescale 1ns / 1ps
// rrat_ram: generic single write, single read ram with registered read data
// no dependencies

module rrat_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rrat_dp.sv -----
`timescale 1ns / 1ps
// rrat_dp: datapath with item latch, packet total, cumulative index,
// received map ram, clear sweep counter and reply register; uses rrat_pkg, rrat_ram

module rrat_dp #(
    parameter int MAX_PACKETS = rrat_pkg::MAX_PACKETS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rrat_pkg::t_cmd                     i_cmd,
    output rrat_pkg::t_sts                     o_sts,
    input  logic                               i_syn_flag,
    input  logic                               i_ack_flag,
    input  logic        [rrat_pkg::SEQ_W-1:0]  i_seq_number,
    input  logic        [rrat_pkg::SEQ_W-1:0]  i_ack_number,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic        [rrat_pkg::KIND_W-1:0] o_reply_kind,
    output logic        [rrat_pkg::SEQ_W-1:0]  o_reply_seq,
    output logic signed [rrat_pkg::ACK_W-1:0]  o_reply_ack,
    output logic                               o_closed_flag
);

    localparam int AW = $clog2(MAX_PACKETS);
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int XW = rrat_pkg::SEQ_W + 1;
    localparam logic [XW-1:0] MAX_X   = XW'(MAX_PACKETS);
    localparam logic [AW-1:0] LAST_AD = AW'(MAX_PACKETS - 1);

    logic                       r_syn;
    logic                       r_ack;
    logic [rrat_pkg::SEQ_W-1:0] r_seq;
    logic [rrat_pkg::SEQ_W-1:0] r_ackn;
    logic [CW-1:0]              r_total;
    logic [CW-1:0]              r_cum;
    logic [AW-1:0]              r_clr;

    logic                       r_o_valid;
    logic [rrat_pkg::KIND_W-1:0] r_o_kind;
    logic [rrat_pkg::SEQ_W-1:0] r_o_seq;
    logic [rrat_pkg::ACK_W-1:0] r_o_ack;
    logic                       r_o_closed;

    logic [XW-1:0] seq_x;
    logic [XW-1:0] total_x;
    logic [XW-1:0] cum_x;
    logic [XW-1:0] synack_x;
    logic [XW-1:0] cumack_x;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_rdata;

    // header latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_syn  <= i_syn_flag;
            r_ack  <= i_ack_flag;
            r_seq  <= i_seq_number;
            r_ackn <= i_ack_number;
        end
    end

    // total, cumulative index and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_cum   <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.load_total) begin
                r_total <= CW'(r_seq);
                r_cum   <= '0;
            end else if (i_cmd.cum_inc) begin
                r_cum <= r_cum + CW'(1);
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // widened copies for compares
    assign seq_x   = {1'b0, r_seq};
    assign total_x = XW'(r_total);
    assign cum_x   = XW'(r_cum);

    // header checks against the current state
    always_comb begin
        o_sts.clear_last = (r_clr == LAST_AD);
        o_sts.syn_ok     = r_syn && (r_seq != '0) && (seq_x <= MAX_X);
        o_sts.confirm_ok = r_ack && (r_ackn == rrat_pkg::CONFIRM_ACK);
        o_sts.data_ok    = (seq_x < total_x);
        o_sts.seq_is_cum = (seq_x == cum_x);
        o_sts.is_last    = (seq_x == total_x - XW'(1));
        o_sts.cum_below  = (r_cum < r_total);
        o_sts.rd_bit     = ram_rdata;
        o_sts.out_free   = !r_o_valid || i_out_ready;
    end

    // received map: the clear sweep or a mark writes, the scan reads
    assign ram_we    = i_cmd.clr_wr || i_cmd.mark_wr;
    assign ram_waddr = i_cmd.clr_wr ? r_clr : r_seq[AW-1:0];

    rrat_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PACKETS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.mark_wr),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_cum[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // reply ack values, wrapped to the field width
    assign synack_x = total_x + XW'(1);
    assign cumack_x = cum_x - XW'(1);

    // reply register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_kind   <= i_cmd.kind;
            r_o_closed <= i_cmd.closed;
            case (i_cmd.kind)
                rrat_pkg::KIND_SYNACK: begin
                    r_o_seq <= rrat_pkg::SYNACK_SEQ;
                    r_o_ack <= synack_x[rrat_pkg::ACK_W-1:0];
                end
                rrat_pkg::KIND_ACK: begin
                    r_o_seq <= '0;
                    r_o_ack <= cumack_x[rrat_pkg::ACK_W-1:0];
                end
                default: begin
                    r_o_seq <= '0;
                    r_o_ack <= '0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_reply_kind  = r_o_kind;
    assign o_reply_seq   = r_o_seq;
    assign o_reply_ack   = $signed(r_o_ack);
    assign o_closed_flag = r_o_closed;

endmodule

// ----- src/rrat_ctrl.sv -----
`timescale 1ns / 1ps
// rrat_ctrl: controller fsm holding the transfer phase and sequencing
// clear sweep, header checks, index scan and reply; uses rrat_pkg

module rrat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrat_pkg::t_sts i_sts,
    output rrat_pkg::t_cmd o_cmd
);

    rrat_pkg::t_state r_state;
    rrat_pkg::t_state n_state;
    rrat_pkg::t_phase r_phase;
    rrat_pkg::t_phase n_phase;
    rrat_pkg::t_kind  r_kind;
    rrat_pkg::t_kind  n_kind;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrat_pkg::S_CLEAR;
            r_phase <= rrat_pkg::PH_WAIT;
            r_kind  <= rrat_pkg::KIND_ERROR;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_kind  <= n_kind;
        end
    end

    // next state, phase and pending reply kind
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_kind  = r_kind;
        case (r_state)
            rrat_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = rrat_pkg::S_IDLE;
                end
            end
            rrat_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rrat_pkg::S_EVAL;
                end
            end
            rrat_pkg::S_EVAL: begin
                n_state = rrat_pkg::S_REPLY;
                n_kind  = rrat_pkg::KIND_ERROR;
                case (r_phase)
                    rrat_pkg::PH_WAIT: begin
                        if (i_sts.syn_ok) begin
                            n_phase = rrat_pkg::PH_CONFIRM;
                            n_kind  = rrat_pkg::KIND_SYNACK;
                        end
                    end
                    rrat_pkg::PH_CONFIRM: begin
                        if (i_sts.confirm_ok) begin
                            n_phase = rrat_pkg::PH_DATA;
                            n_state = rrat_pkg::S_IDLE;
                        end
                    end
                    rrat_pkg::PH_DATA: begin
                        if (i_sts.data_ok) begin
                            n_kind = rrat_pkg::KIND_ACK;
                            if (i_sts.is_last) begin
                                n_phase = rrat_pkg::PH_CLOSED;
                            end
                            if (i_sts.seq_is_cum) begin
                                n_state = rrat_pkg::S_SCAN_RD;
                            end
                        end
                    end
                    default: begin
                        n_kind = rrat_pkg::KIND_ERROR;
                    end
                endcase
            end
            rrat_pkg::S_SCAN_RD: begin
                if (i_sts.cum_below) begin
                    n_state = rrat_pkg::S_SCAN_CHK;
                end else begin
                    n_state = rrat_pkg::S_REPLY;
                end
            end
            rrat_pkg::S_SCAN_CHK: begin
                if (i_sts.rd_bit) begin
                    n_state = rrat_pkg::S_SCAN_RD;
                end else begin
                    n_state = rrat_pkg::S_REPLY;
                end
            end
            rrat_pkg::S_REPLY: begin
                if (i_sts.out_free) begin
                    n_state = rrat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrat_pkg::S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = r_kind;
        o_cmd.closed = (r_phase == rrat_pkg::PH_CLOSED);
        o_in_ready   = 1'b0;
        case (r_state)
            rrat_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            rrat_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            rrat_pkg::S_EVAL: begin
                if (r_phase == rrat_pkg::PH_WAIT) begin
                    o_cmd.load_total = i_sts.syn_ok;
                end
                if (r_phase == rrat_pkg::PH_DATA && i_sts.data_ok) begin
                    o_cmd.mark_wr = 1'b1;
                    o_cmd.cum_inc = i_sts.seq_is_cum;
                end
            end
            rrat_pkg::S_SCAN_RD: begin
                o_cmd.rd_issue = i_sts.cum_below;
            end
            rrat_pkg::S_SCAN_CHK: begin
                o_cmd.cum_inc = i_sts.rd_bit;
            end
            rrat_pkg::S_REPLY: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/reliable_receiver_ack_tracker.sv -----
`timescale 1ns / 1ps
// reliable_receiver_ack_tracker: top level, joins rrat_ctrl and rrat_dp
// depends on rrat_pkg, rrat_in_if, rrat_out_if, rrat_ctrl, rrat_dp
//
//   channel   dir   payload                                          handshake
//   i_pkt     in    syn_flag, ack_flag, seq_number, ack_number       valid/ready
//   o_reply   out   reply_kind, reply_seq, reply_ack, closed_flag    valid/ready
//
// an item passes accept, check and reply load; an in-order packet adds a read
// and a check for each packet the index advances over, one check less at the total
// after reset the received map is swept clear, address by address, with ready low
// a confirming ack passes accept and check only and produces no reply
// a held reply register lets the next header be accepted; a new reply waits
// in the reply state until the previous one has been taken

module reliable_receiver_ack_tracker #(
    parameter int MAX_PACKETS = rrat_pkg::MAX_PACKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrat_in_if.sink     i_pkt,
    rrat_out_if.source  o_reply
);

    rrat_pkg::t_cmd cmd;
    rrat_pkg::t_sts sts;

    // sequencing
    rrat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .o_in_ready (i_pkt.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and checks
    rrat_dp #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_syn_flag    (i_pkt.syn_flag),
        .i_ack_flag    (i_pkt.ack_flag),
        .i_seq_number  (i_pkt.seq_number),
        .i_ack_number  (i_pkt.ack_number),
        .i_out_ready   (o_reply.ready),
        .o_out_valid   (o_reply.valid),
        .o_reply_kind  (o_reply.reply_kind),
        .o_reply_seq   (o_reply.reply_seq),
        .o_reply_ack   (o_reply.reply_ack),
        .o_closed_flag (o_reply.closed_flag)
    );

endmodule
